/* rtl/core/bktk_pkg.sv */
// Shared types and ranking functions for the bucketed top-k keeper.
// Holds the channel record, its score and the strength order.
// No dependencies.
package bktk_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	typedef struct packed {
		logic [63:0] cand_hi;
		logic [63:0] cand_lo;
		logic [63:0] rel_hi;
		logic [63:0] rel_lo;
		logic        outbound;
		logic [63:0] rating;
		logic [63:0] deviation;
		logic [31:0] witnesses;
	} chan_t;

	localparam int CHAN_W = $bits(chan_t);

	typedef logic signed [65:0] score_t;

	typedef struct packed {
		logic [6:0] ordinal;
		chan_t      chan;
		logic       is_last;
		logic       is_empty;
	} res_t;

	function automatic score_t score_of(input chan_t c);
		score_t r;
		score_t d2;
		r  = signed'({{2{c.rating[63]}}, c.rating});
		d2 = signed'({c.deviation[63], c.deviation, 1'b0});
		return r - d2;
	endfunction

	// true when a ranks strictly above b
	function automatic logic stronger(input chan_t a, input score_t sa,
		input chan_t b, input score_t sb);
		logic [255:0] ka;
		logic [255:0] kb;
		logic         r;
		ka = {a.cand_hi, a.cand_lo, a.rel_hi, a.rel_lo};
		kb = {b.cand_hi, b.cand_lo, b.rel_hi, b.rel_lo};
		if (sa != sb) begin
			r = sa > sb;
		end else if (ka != kb) begin
			r = ka < kb;
		end else begin
			r = a.outbound & ~b.outbound;
		end
		return r;
	endfunction

	function automatic logic key_eq(input chan_t a, input chan_t b);
		return {a.cand_hi, a.cand_lo, a.rel_hi, a.rel_lo, a.outbound} ==
			{b.cand_hi, b.cand_lo, b.rel_hi, b.rel_lo, b.outbound};
	endfunction

endpackage

/* rtl/core/bktk_ram.sv */
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module bktk_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/core/bktk_engine.sv */
// Heap engine: per-bucket min-heaps in a slot RAM, fill counts in a fill RAM.
// Runs key scan, sift up, sift down and the drain heap sort over one read port.
// Depends on bktk_pkg and bktk_ram.
module bktk_engine #(
	parameter int BUCKETS    = 64,
	parameter int MAX_FANOUT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bktk_pkg::op_t   op,
	input  logic [6:0]      ordinal,
	input  bktk_pkg::chan_t chan,
	input  logic [6:0]      fanout,
	output logic            busy,
	output logic            res_valid,
	output bktk_pkg::res_t  res
);
	import bktk_pkg::*;

	localparam int SLOTS = BUCKETS * MAX_FANOUT;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW    = $clog2(MAX_FANOUT + 1);

	typedef enum logic [15:0] {
		ST_CLR      = 16'b0000000000000001,
		ST_IDLE     = 16'b0000000000000010,
		ST_FILL     = 16'b0000000000000100,
		ST_SCAN_RD  = 16'b0000000000001000,
		ST_SCAN_CK  = 16'b0000000000010000,
		ST_ROOT_CK  = 16'b0000000000100000,
		ST_UP_RD    = 16'b0000000001000000,
		ST_UP_CK    = 16'b0000000010000000,
		ST_SD_CHK   = 16'b0000000100000000,
		ST_SD_C1    = 16'b0000001000000000,
		ST_SD_C2    = 16'b0000010000000000,
		ST_SD_DEC   = 16'b0000100000000000,
		ST_POP_RD   = 16'b0001000000000000,
		ST_POP_TAKE = 16'b0010000000000000,
		ST_POP_LAST = 16'b0100000000000000,
		ST_OUT      = 16'b1000000000000000
	} state_t;

	state_t          state_q, state_d;
	logic [BW-1:0]   clr_q, clr_d;
	chan_t           c_q, c_d, best_q, best_d;
	score_t          cs_q, cs_d, bs_q, bs_d;
	op_t             op_q, op_d;
	logic [6:0]      ord_q, ord_d;
	logic [BW-1:0]   bkt_q, bkt_d;
	logic [AW-1:0]   base_q, base_d;
	logic [FW-1:0]   n_q, n_d, idx_q, idx_d, child_q, child_d, tot_q, tot_d;
	res_t            res_q, res_d;
	logic            res_v_q, res_v_d;

	logic            s_re, s_we, f_re, f_we;
	logic [AW-1:0]   s_raddr, s_waddr;
	logic [BW-1:0]   f_raddr, f_waddr;
	logic [CHAN_W-1:0] s_rdata, s_wdata;
	logic [FW-1:0]   f_rdata, f_wdata;

	chan_t           rd;
	score_t          rd_s;
	logic            in_ok;
	logic [BW-1:0]   in_bkt;
	logic [AW-1:0]   in_base;
	logic [FW-1:0]   left, parent;
	res_t            empty_res;

	bktk_ram #(.DEPTH(SLOTS), .WIDTH(CHAN_W), .AW(AW)) u_slot_ram (
		.clk   (clk),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata)
	);

	bktk_ram #(.DEPTH(BUCKETS), .WIDTH(FW), .AW(BW)) u_fill_ram (
		.clk   (clk),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata)
	);

	assign rd      = chan_t'(s_rdata);
	assign rd_s    = score_of(rd);
	assign in_ok   = (ordinal != 7'd0) && (11'(ordinal) <= 11'(BUCKETS));
	assign in_bkt  = BW'(ordinal - 7'd1);
	assign in_base = AW'(in_bkt) * AW'(MAX_FANOUT);
	assign left    = FW'({idx_q, 1'b0}) + FW'(1);
	assign parent  = (idx_q - FW'(1)) >> 1;

	always_comb begin
		empty_res          = '0;
		empty_res.ordinal  = (state_q == ST_IDLE) ? ordinal : ord_q;
		empty_res.is_last  = 1'b1;
		empty_res.is_empty = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		c_d     = c_q;
		cs_d    = cs_q;
		best_d  = best_q;
		bs_d    = bs_q;
		op_d    = op_q;
		ord_d   = ord_q;
		bkt_d   = bkt_q;
		base_d  = base_q;
		n_d     = n_q;
		idx_d   = idx_q;
		child_d = child_q;
		tot_d   = tot_q;
		res_d   = res_q;
		res_v_d = 1'b0;
		s_re    = 1'b0;
		s_raddr = base_q;
		s_we    = 1'b0;
		s_waddr = base_q + AW'(idx_q);
		s_wdata = c_q;
		f_re    = 1'b0;
		f_raddr = bkt_q;
		f_we    = 1'b0;
		f_waddr = bkt_q;
		f_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				f_we    = 1'b1;
				f_waddr = clr_q;
				clr_d   = clr_q + BW'(1);
				if (clr_q == BW'(BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					c_d    = chan;
					cs_d   = score_of(chan);
					op_d   = op;
					ord_d  = ordinal;
					bkt_d  = in_bkt;
					base_d = in_base;
					if (!in_ok) begin
						if (op == OP_DRAIN) begin
							res_v_d = 1'b1;
							res_d   = empty_res;
						end
					end else if (!(op == OP_INSERT && fanout == 7'd0)) begin
						f_re    = 1'b1;
						f_raddr = in_bkt;
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				n_d   = f_rdata;
				idx_d = '0;
				if (op_q == OP_DRAIN) begin
					f_we = 1'b1;
					if (f_rdata == '0) begin
						res_v_d = 1'b1;
						res_d   = empty_res;
						state_d = ST_IDLE;
					end else begin
						tot_d   = f_rdata;
						s_re    = 1'b1;
						s_raddr = base_q;
						state_d = ST_POP_TAKE;
					end
				end else if (f_rdata == '0) begin
					f_we    = 1'b1;
					f_wdata = FW'(1);
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				s_re    = 1'b1;
				s_raddr = base_q + AW'(idx_q);
				state_d = ST_SCAN_CK;
			end
			ST_SCAN_CK: begin
				if (key_eq(rd, c_q)) begin
					state_d = stronger(c_q, cs_q, rd, rd_s) ? ST_SD_CHK : ST_IDLE;
				end else if (idx_q + FW'(1) < n_q) begin
					idx_d   = idx_q + FW'(1);
					state_d = ST_SCAN_RD;
				end else if (7'(n_q) >= fanout) begin
					s_re    = 1'b1;
					s_raddr = base_q;
					idx_d   = '0;
					state_d = ST_ROOT_CK;
				end else begin
					f_we    = 1'b1;
					f_wdata = n_q + FW'(1);
					idx_d   = n_q;
					state_d = ST_UP_RD;
				end
			end
			ST_ROOT_CK: begin
				state_d = stronger(c_q, cs_q, rd, rd_s) ? ST_SD_CHK : ST_IDLE;
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					s_we    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					s_re    = 1'b1;
					s_raddr = base_q + AW'(parent);
					child_d = parent;
					state_d = ST_UP_CK;
				end
			end
			ST_UP_CK: begin
				s_we = 1'b1;
				if (stronger(rd, rd_s, c_q, cs_q)) begin
					s_wdata = rd;
					idx_d   = child_q;
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SD_CHK: begin
				if (idx_q < (n_q >> 1)) begin
					s_re    = 1'b1;
					s_raddr = base_q + AW'(left);
					child_d = left;
					state_d = ST_SD_C1;
				end else begin
					s_we    = 1'b1;
					state_d = (op_q == OP_DRAIN) ? ST_POP_RD : ST_IDLE;
				end
			end
			ST_SD_C1: begin
				best_d = rd;
				bs_d   = rd_s;
				if (child_q + FW'(1) < n_q) begin
					s_re    = 1'b1;
					s_raddr = base_q + AW'(child_q + FW'(1));
					state_d = ST_SD_C2;
				end else begin
					state_d = ST_SD_DEC;
				end
			end
			ST_SD_C2: begin
				if (stronger(best_q, bs_q, rd, rd_s)) begin
					best_d  = rd;
					bs_d    = rd_s;
					child_d = child_q + FW'(1);
				end
				state_d = ST_SD_DEC;
			end
			ST_SD_DEC: begin
				s_we = 1'b1;
				if (stronger(c_q, cs_q, best_q, bs_q)) begin
					s_wdata = best_q;
					idx_d   = child_q;
					state_d = ST_SD_CHK;
				end else begin
					state_d = (op_q == OP_DRAIN) ? ST_POP_RD : ST_IDLE;
				end
			end
			ST_POP_RD: begin
				s_re    = 1'b1;
				s_raddr = base_q;
				state_d = ST_POP_TAKE;
			end
			ST_POP_TAKE: begin
				best_d = rd;
				n_d    = n_q - FW'(1);
				s_re   = 1'b1;
				if (n_q == FW'(1)) begin
					s_raddr = base_q;
					idx_d   = '0;
					state_d = ST_OUT;
				end else begin
					s_raddr = base_q + AW'(n_q - FW'(1));
					state_d = ST_POP_LAST;
				end
			end
			ST_POP_LAST: begin
				s_we    = 1'b1;
				s_waddr = base_q + AW'(n_q);
				s_wdata = best_q;
				c_d     = rd;
				cs_d    = rd_s;
				idx_d   = '0;
				state_d = ST_SD_CHK;
			end
			ST_OUT: begin
				res_v_d        = 1'b1;
				res_d.ordinal  = ord_q;
				res_d.chan     = rd;
				res_d.is_last  = (idx_q + FW'(1) == tot_q);
				res_d.is_empty = 1'b0;
				if (idx_q + FW'(1) == tot_q) begin
					state_d = ST_IDLE;
				end else begin
					s_re    = 1'b1;
					s_raddr = base_q + AW'(idx_q + FW'(1));
					idx_d   = idx_q + FW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			res_v_q <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		c_q     <= c_d;
		cs_q    <= cs_d;
		best_q  <= best_d;
		bs_q    <= bs_d;
		op_q    <= op_d;
		ord_q   <= ord_d;
		bkt_q   <= bkt_d;
		base_q  <= base_d;
		n_q     <= n_d;
		idx_q   <= idx_d;
		child_q <= child_d;
		tot_q   <= tot_d;
		res_q   <= res_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_v_q;
	assign res       = res_q;
endmodule

/* rtl/core/bucketed_top_k_keeper.sv */
// Top level: per-bucket top-k keeper with fanout register and result ports.
// Insert: reads the bucket's fill count, scans the kept keys, then sifts the heap.
// Drain of n: in-place heap sort of the bucket's kept channels,
// then n results on consecutive cycles, strongest first. One request at a time.
// After reset the fill RAM is cleared, one bucket a cycle, with busy high.
// Results are never stalled; max_kept resets to 16. Depends on bktk_pkg and bktk_engine.
module bucketed_top_k_keeper #(
	parameter int BUCKETS    = 64,
	parameter int MAX_FANOUT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               opcode,
	input  logic [6:0]         ordinal,
	input  logic [63:0]        candidate_hi,
	input  logic [63:0]        candidate_lo,
	input  logic [63:0]        relation_hi,
	input  logic [63:0]        relation_lo,
	input  logic               outbound,
	input  logic signed [63:0] rating,
	input  logic signed [63:0] deviation,
	input  logic [31:0]        witnesses,
	output logic               out_valid,
	output logic [6:0]         out_ordinal,
	output logic [63:0]        out_candidate_hi,
	output logic [63:0]        out_candidate_lo,
	output logic [63:0]        out_relation_hi,
	output logic [63:0]        out_relation_lo,
	output logic               out_outbound,
	output logic signed [63:0] out_rating,
	output logic signed [63:0] out_deviation,
	output logic [31:0]        out_witnesses,
	output logic               is_last,
	output logic               is_empty
);
	import bktk_pkg::*;

	logic [4:0] max_kept_q;
	logic [6:0] fanout;
	chan_t      in_chan;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kept_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			max_kept_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign fanout    = (7'(max_kept_q) > 7'(MAX_FANOUT)) ? 7'(MAX_FANOUT) : 7'(max_kept_q);

	always_comb begin
		in_chan.cand_hi   = candidate_hi;
		in_chan.cand_lo   = candidate_lo;
		in_chan.rel_hi    = relation_hi;
		in_chan.rel_lo    = relation_lo;
		in_chan.outbound  = outbound;
		in_chan.rating    = unsigned'(rating);
		in_chan.deviation = unsigned'(deviation);
		in_chan.witnesses = witnesses;
	end

	bktk_engine #(.BUCKETS(BUCKETS), .MAX_FANOUT(MAX_FANOUT)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op_t'(opcode)),
		.ordinal   (ordinal),
		.chan      (in_chan),
		.fanout    (fanout),
		.busy      (busy),
		.res_valid (out_valid),
		.res       (res)
	);

	assign out_ordinal      = res.ordinal;
	assign out_candidate_hi = res.chan.cand_hi;
	assign out_candidate_lo = res.chan.cand_lo;
	assign out_relation_hi  = res.chan.rel_hi;
	assign out_relation_lo  = res.chan.rel_lo;
	assign out_outbound     = res.chan.outbound;
	assign out_rating       = signed'(res.chan.rating);
	assign out_deviation    = signed'(res.chan.deviation);
	assign out_witnesses    = res.chan.witnesses;
	assign is_last          = res.is_last;
	assign is_empty         = res.is_empty;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> is_last && out_rating == 64'sd0 && out_candidate_hi == 64'd0)
		else $error("empty result not final or not zero");

	a_insert_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_INSERT |=> !out_valid)
		else $error("insert produced a result");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> busy)
		else $error("drain stopped before final result");
endmodule

/* tb/tb_keeper_checker.sv */
// Checker for the bucketed top-k keeper: watches requests, the fanout channel and results.
// Keeps its own per-bucket copy of the kept channels and compares every result.
// Depends on bktk_pkg.
`timescale 1ns / 100ps
module tb_keeper_checker #(
	parameter int BUCKETS    = 64,
	parameter int MAX_FANOUT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               opcode,
	input  logic [6:0]         ordinal,
	input  logic [63:0]        candidate_hi,
	input  logic [63:0]        candidate_lo,
	input  logic [63:0]        relation_hi,
	input  logic [63:0]        relation_lo,
	input  logic               outbound,
	input  logic signed [63:0] rating,
	input  logic signed [63:0] deviation,
	input  logic [31:0]        witnesses,
	input  logic               out_valid,
	input  logic [6:0]         out_ordinal,
	input  logic [63:0]        out_candidate_hi,
	input  logic [63:0]        out_candidate_lo,
	input  logic [63:0]        out_relation_hi,
	input  logic [63:0]        out_relation_lo,
	input  logic               out_outbound,
	input  logic signed [63:0] out_rating,
	input  logic signed [63:0] out_deviation,
	input  logic [31:0]        out_witnesses,
	input  logic               is_last,
	input  logic               is_empty,
	output int                 fail_count,
	output int                 pending
);
	import bktk_pkg::*;

	chan_t kept [BUCKETS][MAX_FANOUT];
	int    fill [BUCKETS];
	int    fanout;
	res_t  drain_queue [$];

	function automatic logic signed [65:0] strength(input chan_t c);
		logic signed [65:0] r;
		logic signed [65:0] d;
		r = 66'(signed'(c.rating));
		d = 66'(signed'(c.deviation));
		return r - d - d;
	endfunction

	// 1 when a ranks strictly above b
	function automatic bit beats(input chan_t a, input chan_t b);
		logic signed [65:0] sa;
		logic signed [65:0] sb;
		logic [255:0] ka;
		logic [255:0] kb;
		sa = strength(a);
		sb = strength(b);
		ka = {a.cand_hi, a.cand_lo, a.rel_hi, a.rel_lo};
		kb = {b.cand_hi, b.cand_lo, b.rel_hi, b.rel_lo};
		if (sa != sb) return sa > sb;
		if (ka != kb) return ka < kb;
		return a.outbound && !b.outbound;
	endfunction

	function automatic bit same_key(input chan_t a, input chan_t b);
		return {a.cand_hi, a.cand_lo, a.rel_hi, a.rel_lo, a.outbound} ==
			{b.cand_hi, b.cand_lo, b.rel_hi, b.rel_lo, b.outbound};
	endfunction

	task automatic push_down(input int b, input int n, input int at, input chan_t c);
		int    child;
		chan_t cc;
		while (at < n / 2) begin
			child = at * 2 + 1;
			cc = kept[b][child];
			if (child + 1 < n && beats(cc, kept[b][child + 1])) begin
				child++;
				cc = kept[b][child];
			end
			if (!beats(c, cc)) break;
			kept[b][at] = cc;
			at = child;
		end
		kept[b][at] = c;
	endtask

	task automatic keep_channel(input int b, input chan_t c);
		int f;
		int n;
		int at;
		int parent;
		f = (fanout > MAX_FANOUT) ? MAX_FANOUT : fanout;
		n = fill[b];
		if (f == 0) return;
		for (int i = 0; i < n; i++) begin
			if (same_key(kept[b][i], c)) begin
				if (beats(c, kept[b][i])) push_down(b, n, i, c);
				return;
			end
		end
		if (n >= f) begin
			if (beats(c, kept[b][0])) push_down(b, n, 0, c);
			return;
		end
		at = n;
		fill[b] = n + 1;
		while (at > 0) begin
			parent = (at - 1) / 2;
			if (!beats(kept[b][parent], c)) break;
			kept[b][at] = kept[b][parent];
			at = parent;
		end
		kept[b][at] = c;
	endtask

	task automatic drain_bucket(input logic [6:0] ord);
		chan_t list [$];
		chan_t t;
		res_t  r;
		int    best;
		if (ord >= 1 && ord <= BUCKETS) begin
			for (int i = 0; i < fill[ord - 1]; i++) list.push_back(kept[ord - 1][i]);
			fill[ord - 1] = 0;
		end
		if (list.size() == 0) begin
			r = '0;
			r.ordinal = ord;
			r.is_last = 1'b1;
			r.is_empty = 1'b1;
			drain_queue.push_back(r);
			return;
		end
		for (int i = 0; i + 1 < list.size(); i++) begin
			best = i;
			for (int j = i + 1; j < list.size(); j++)
				if (beats(list[j], list[best])) best = j;
			t = list[i];
			list[i] = list[best];
			list[best] = t;
		end
		foreach (list[i]) begin
			r = '0;
			r.ordinal = ord;
			r.chan = list[i];
			r.is_last = (i == list.size() - 1);
			drain_queue.push_back(r);
		end
	endtask

	task automatic report(input res_t want, input res_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: expected %h got %h", $realtime, want, got);
	endtask

	assign pending = drain_queue.size();

	always @(posedge clk or negedge arst_n) begin
		chan_t c;
		res_t  got;
		res_t  want;
		if (!arst_n) begin
			foreach (fill[i]) fill[i] = 0;
			fanout = 16;
			fail_count = 0;
			drain_queue.delete();
		end else begin
			if (out_valid) begin
				got.ordinal = out_ordinal;
				got.chan = {out_candidate_hi, out_candidate_lo, out_relation_hi,
					out_relation_lo, out_outbound, out_rating, out_deviation, out_witnesses};
				got.is_last = is_last;
				got.is_empty = is_empty;
				if (drain_queue.size() == 0) begin
					report('x, got);
				end else begin
					want = drain_queue.pop_front();
					if (got !== want) report(want, got);
				end
			end
			if (cfg_valid && cfg_ready) fanout = cfg_data;
			if (start && !busy) begin
				c = {candidate_hi, candidate_lo, relation_hi, relation_lo, outbound,
					rating, deviation, witnesses};
				if (opcode == OP_DRAIN) begin
					drain_bucket(ordinal);
				end else if (ordinal >= 1 && ordinal <= BUCKETS) begin
					keep_channel(ordinal - 1, c);
				end
			end
		end
	end

endmodule

/* tb/tb_top.sv */
// Top of the bucketed top-k keeper testbench: clock, reset, requests and verdict.
// Drives directed then random inserts and drains under several fanouts and gap patterns.
// Depends on bktk_pkg, bucketed_top_k_keeper and tb_keeper_checker.
`timescale 1ns / 100ps
module tb_top;
	import bktk_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = '0;
	logic               opcode = OP_INSERT;
	logic [6:0]         ordinal = 7'd1;
	logic [63:0]        candidate_hi = '0;
	logic [63:0]        candidate_lo = '0;
	logic [63:0]        relation_hi = '0;
	logic [63:0]        relation_lo = '0;
	logic               outbound = 1'b0;
	logic signed [63:0] rating = '0;
	logic signed [63:0] deviation = '0;
	logic [31:0]        witnesses = '0;
	logic               out_valid;
	logic [6:0]         out_ordinal;
	logic [63:0]        out_candidate_hi;
	logic [63:0]        out_candidate_lo;
	logic [63:0]        out_relation_hi;
	logic [63:0]        out_relation_lo;
	logic               out_outbound;
	logic signed [63:0] out_rating;
	logic signed [63:0] out_deviation;
	logic [31:0]        out_witnesses;
	logic               is_last;
	logic               is_empty;
	int                 fail_count;
	int                 pending;
	int                 idle_pct;
	logic [63:0]        cand_pool [8];
	logic [63:0]        rel_pool [4];

	always #5 clk = ~clk;

	bucketed_top_k_keeper u_dut (.*);

	tb_keeper_checker u_chk (.*);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return '0;
			default: return rand64();
		endcase
	endfunction

	task automatic send(input op_t op, input logic [6:0] ord, input logic [63:0] ch,
		input logic [63:0] cl, input logic [63:0] rh, input logic [63:0] rl,
		input logic dir, input logic [63:0] rt, input logic [63:0] dv, input logic [31:0] wt);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		ordinal <= ord;
		candidate_hi <= ch;
		candidate_lo <= cl;
		relation_hi <= rh;
		relation_lo <= rl;
		outbound <= dir;
		rating <= rt;
		deviation <= dv;
		witnesses <= wt;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_insert(input logic [6:0] ord);
		if ($urandom_range(0, 3) == 0)
			send(OP_INSERT, ord, rand64(), rand64(), rand64(), rand64(), 1'($urandom()),
				edge64(), edge64(), $urandom());
		else
			send(OP_INSERT, ord, cand_pool[$urandom_range(0, 7)], cand_pool[$urandom_range(0, 1)],
				rel_pool[$urandom_range(0, 3)], rel_pool[$urandom_range(0, 1)], 1'($urandom()),
				64'(signed'($urandom_range(0, 40)) - 20), 64'(signed'($urandom_range(0, 8)) - 4),
				$urandom());
	endtask

	task automatic settle_and_write(input logic [4:0] value);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [4:0] fanouts [5];
		int         pcts [4];
		fanouts = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1};
		pcts = '{0, 76, 0, 31};
		idle_pct = 0;
		foreach (cand_pool[i]) cand_pool[i] = rand64();
		cand_pool[0] = '0;
		cand_pool[1] = '1;
		foreach (rel_pool[i]) rel_pool[i] = rand64();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_DRAIN, 7'd1, '0, '0, '0, '0, 1'b0, '0, '0, '0);
		send(OP_DRAIN, 7'd0, '1, '1, '1, '1, 1'b1, '1, '1, '1);
		send(OP_DRAIN, 7'd127, '0, '0, '0, '0, 1'b0, '0, '0, '0);
		send(OP_INSERT, 7'd0, '1, '1, '1, '1, 1'b1, '1, '1, '1);
		send(OP_INSERT, 7'd65, '1, '1, '1, '1, 1'b1, '1, '1, '1);
		send(OP_INSERT, 7'd64, '1, '1, '1, '1, 1'b1, 64'h7fff_ffff_ffff_ffff,
			64'h8000_0000_0000_0000, '1);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b0, 64'h8000_0000_0000_0000,
			64'h7fff_ffff_ffff_ffff, '0);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b1, '0, '0, 32'h1);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b0, '0, '0, 32'h2);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b0, 64'd2, 64'd1, 32'h3);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b0, 64'd5, '0, 32'h4);
		send(OP_INSERT, 7'd64, '0, '0, '0, '0, 1'b0, 64'd1, '0, 32'h5);
		send(OP_DRAIN, 7'd64, '0, '0, '0, '0, 1'b0, '0, '0, '0);
		for (int i = 0; i < 18; i++) random_insert(7'd2);
		send(OP_DRAIN, 7'd2, '0, '0, '0, '0, 1'b0, '0, '0, '0);

		foreach (fanouts[p]) begin
			settle_and_write(fanouts[p]);
			idle_pct = pcts[p % 4];
			for (int n = 0; n < 80; n++) begin
				if ($urandom_range(0, 9) == 0)
					send(OP_DRAIN, 7'($urandom_range(0, 6)), rand64(), rand64(), rand64(),
						rand64(), 1'($urandom()), rand64(), rand64(), $urandom());
				else
					random_insert(7'($urandom_range(0, 20) == 0 ? $urandom_range(0, 127)
						: $urandom_range(1, 6)));
				if (n % 40 == 39)
					for (int b = 1; b <= 6; b++)
						send(OP_DRAIN, 7'(b), '0, '0, '0, '0, 1'b0, '0, '0, '0);
			end
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* bucketed_top_k_keeper.f */
rtl/core/bktk_pkg.sv
rtl/core/bktk_ram.sv
rtl/core/bktk_engine.sv
rtl/core/bucketed_top_k_keeper.sv
tb/tb_keeper_checker.sv
tb/tb_top.sv
